FILE: rtl/wpw_pkg.sv
package wpw_pkg;

    localparam int          TABLE_DEPTH_DEF  = 1024;
    localparam logic [16:0] MAX_FRAME        = 17'd65536;
    localparam logic [16:0] FRAME_LENGTH_RST = 17'd65536;
    localparam int          PADDR_W          = 5;
    localparam int          PDATA_W          = 32;

    localparam logic [2:0] MODE_SQUARE   = 3'd0;
    localparam logic [2:0] MODE_TRIANGLE = 3'd1;
    localparam logic [2:0] MODE_COS      = 3'd2;
    localparam logic [2:0] MODE_COS_SQ   = 3'd3;
    localparam logic [2:0] MODE_CARRIER  = 3'd4;

    localparam logic [2:0] REG_WAVE_MODE    = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [2:0] REG_HALF_WIDTH   = 3'd2;
    localparam logic [2:0] REG_FRAME_LENGTH = 3'd3;
    localparam logic [2:0] REG_PHASE_STEP   = 3'd4;
    localparam logic [2:0] REG_RAMP_SLOPE   = 3'd5;

    typedef struct packed {
        logic [2:0]  wave_mode;
        logic [14:0] amplitude;
        logic [16:0] half_width;
        logic [16:0] frame_length;
        logic [31:0] phase_step;
        logic [31:0] ramp_slope;
    } t_cfg;

    function automatic logic signed [15:0] sat16(input logic signed [49:0] v);
        logic signed [15:0] res;
        if (v > 50'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -50'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // quarter wave entry, q30 taylor series to x^14, rounded to q15
    function automatic logic [15:0] cos_entry(input int k, input int log2_depth);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q;
        x    = (64'(k) * 64'd3373259426) >> (log2_depth + 1);
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sum  = 64'sd1 << 30;
        term = ((term * x2) >> 30) / 64'd2;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd12;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd30;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd56;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd90;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd132;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd182;
        sum  = sum - $signed(term);
        if (sum < 0) begin
            sum = '0;
        end
        q = ($unsigned(sum) + 64'd16384) >> 15;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

endpackage

FILE: rtl/wpw_cfg.sv
module wpw_cfg
    import wpw_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [2:0] w_idx;
    logic       w_wr;

    assign w_idx  = paddr[PADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                REG_WAVE_MODE:    n_cfg.wave_mode    = pwdata[2:0];
                REG_AMPLITUDE:    n_cfg.amplitude    = pwdata[14:0];
                REG_HALF_WIDTH:   n_cfg.half_width   = pwdata[16:0];
                REG_FRAME_LENGTH: n_cfg.frame_length = pwdata[16:0];
                REG_PHASE_STEP:   n_cfg.phase_step   = pwdata;
                REG_RAMP_SLOPE:   n_cfg.ramp_slope   = pwdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wave_mode    <= MODE_SQUARE;
            r_cfg.amplitude    <= '0;
            r_cfg.half_width   <= '0;
            r_cfg.frame_length <= FRAME_LENGTH_RST;
            r_cfg.phase_step   <= '0;
            r_cfg.ramp_slope   <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_WAVE_MODE:    prdata = {29'd0, r_cfg.wave_mode};
            REG_AMPLITUDE:    prdata = {17'd0, r_cfg.amplitude};
            REG_HALF_WIDTH:   prdata = {15'd0, r_cfg.half_width};
            REG_FRAME_LENGTH: prdata = {15'd0, r_cfg.frame_length};
            REG_PHASE_STEP:   prdata = r_cfg.phase_step;
            REG_RAMP_SLOPE:   prdata = r_cfg.ramp_slope;
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: rtl/wpw_cos_rom.sv
module wpw_cos_rom
    import wpw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0] i_addr,
    output logic [15:0]                    o_data
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [15:0] w_rom [TABLE_DEPTH];
    logic [15:0] r_data;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
        assign w_rom[k] = cos_entry(k, AW);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

FILE: rtl/wpw_datapath.sv
module wpw_datapath
    import wpw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_sample_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample_value,
    output logic signed [15:0] o_center_offset
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NS = 6;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] w_ld;

    always_comb begin
        w_ld[NS-1] = !r_vld[NS-1] | i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] | w_ld[k+1];
        end
        n_vld = r_vld;
        if (w_ld[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_ld[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_ld[0];
    assign o_valid = r_vld[NS-1];

    // stage 1: frame offset and window test
    logic [16:0]        w_len_clip;
    logic [16:0]        w_len;
    logic signed [16:0] w_d;
    logic signed [16:0] w_neg_d;
    logic [15:0]        w_mag;
    logic               w_zero;
    logic               w_inside;

    assign w_len_clip = (i_cfg.frame_length > MAX_FRAME) ? MAX_FRAME : i_cfg.frame_length;
    assign w_len      = {w_len_clip[16:1], 1'b0};
    assign w_d        = $signed({1'b0, i_sample_index}) - $signed({1'b0, w_len[16:1]});
    assign w_neg_d    = -w_d;
    assign w_mag      = w_d[16] ? w_neg_d[15:0] : w_d[15:0];
    assign w_zero     = (i_sample_index == '0) || ({1'b0, i_sample_index} >= w_len);
    assign w_inside   = ({1'b0, w_mag} < i_cfg.half_width);

    logic               r1_zero;
    logic               r1_inside;
    logic signed [15:0] r1_d;
    logic [15:0]        r1_mag;

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r1_zero   <= w_zero;
            r1_inside <= w_inside;
            r1_d      <= w_d[15:0];
            r1_mag    <= w_mag;
        end
    end

    // stage 2: phase and ramp products
    logic [47:0] w_ph_prod;
    logic [47:0] w_rs_prod;

    assign w_ph_prod = 48'(i_cfg.phase_step) * 48'(r1_mag);
    assign w_rs_prod = 48'(i_cfg.ramp_slope) * 48'(r1_mag);

    logic               r2_zero;
    logic               r2_inside;
    logic signed [15:0] r2_d;
    logic [31:0]        r2_phase;
    logic [47:0]        r2_ramp;

    always_ff @(posedge i_clk) begin
        if (w_ld[1]) begin
            r2_zero   <= r1_zero;
            r2_inside <= r1_inside;
            r2_d      <= r1_d;
            r2_phase  <= w_ph_prod[31:0];
            r2_ramp   <= w_rs_prod;
        end
    end

    // stage 3: table address, rom read, triangle
    logic [1:0]         w_quad;
    logic [AW-1:0]      w_pos;
    logic [AW:0]        w_mir;
    logic [AW-1:0]      w_addr;
    logic               w_cz;
    logic [15:0]        w_rom;
    logic signed [49:0] w_v;
    logic signed [49:0] w_t;

    assign w_quad = r2_phase[31:30];
    assign w_pos  = r2_phase[29 -: AW];
    assign w_mir  = (AW+1)'(TABLE_DEPTH) - {1'b0, w_pos};
    assign w_addr = w_quad[0] ? w_mir[AW-1:0] : w_pos;
    assign w_cz   = w_quad[0] && (w_pos == '0);
    assign w_v    = $signed({19'd0, i_cfg.amplitude, 16'd0}) - $signed({2'd0, r2_ramp});
    assign w_t    = (w_v + 50'sd32768) >>> 16;

    wpw_cos_rom #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_rom (
        .i_clk (i_clk),
        .i_en  (w_ld[2]),
        .i_addr(w_addr),
        .o_data(w_rom)
    );

    logic               r3_zero;
    logic               r3_inside;
    logic signed [15:0] r3_d;
    logic               r3_neg;
    logic               r3_cz;
    logic signed [15:0] r3_tri;

    always_ff @(posedge i_clk) begin
        if (w_ld[2]) begin
            r3_zero   <= r2_zero;
            r3_inside <= r2_inside;
            r3_d      <= r2_d;
            r3_neg    <= w_quad[1] ^ w_quad[0];
            r3_cz     <= w_cz;
            r3_tri    <= sat16(w_t);
        end
    end

    // stage 4: signed cosine, a*c and c*c
    logic signed [16:0] w_c;
    logic signed [32:0] w_ac;
    logic signed [33:0] w_cc;

    always_comb begin
        if (r3_cz) begin
            w_c = '0;
        end else if (r3_neg) begin
            w_c = -$signed({1'b0, w_rom});
        end else begin
            w_c = $signed({1'b0, w_rom});
        end
    end

    assign w_ac = 33'($signed({1'b0, i_cfg.amplitude})) * 33'(w_c);
    assign w_cc = 34'(w_c) * 34'(w_c);

    logic               r4_zero;
    logic               r4_inside;
    logic signed [15:0] r4_d;
    logic signed [15:0] r4_tri;
    logic signed [32:0] r4_ac;
    logic [30:0]        r4_cc;

    always_ff @(posedge i_clk) begin
        if (w_ld[3]) begin
            r4_zero   <= r3_zero;
            r4_inside <= r3_inside;
            r4_d      <= r3_d;
            r4_tri    <= r3_tri;
            r4_ac     <= w_ac;
            r4_cc     <= w_cc[30:0];
        end
    end

    // stage 5: round, a*c^2
    logic [30:0]        w_cc_rnd;
    logic [15:0]        w_c2;
    logic [30:0]        w_ac2;
    logic signed [32:0] w_ac_rnd;

    assign w_cc_rnd = (r4_cc + 31'd16384) >> 15;
    assign w_c2     = w_cc_rnd[15:0];
    assign w_ac2    = 31'(i_cfg.amplitude) * 31'(w_c2);
    assign w_ac_rnd = (r4_ac + 33'sd16384) >>> 15;

    logic               r5_zero;
    logic               r5_inside;
    logic signed [15:0] r5_d;
    logic signed [15:0] r5_tri;
    logic signed [15:0] r5_cos;
    logic [30:0]        r5_ac2;

    always_ff @(posedge i_clk) begin
        if (w_ld[4]) begin
            r5_zero   <= r4_zero;
            r5_inside <= r4_inside;
            r5_d      <= r4_d;
            r5_tri    <= r4_tri;
            r5_cos    <= sat16(50'(w_ac_rnd));
            r5_ac2    <= w_ac2;
        end
    end

    // stage 6: mode select, output register
    logic [30:0]        w_sq_rnd;
    logic signed [15:0] w_sq;
    logic signed [15:0] w_val;

    assign w_sq_rnd = (r5_ac2 + 31'd16384) >> 15;
    assign w_sq     = sat16($signed({19'd0, w_sq_rnd}));

    always_comb begin
        w_val = '0;
        case (i_cfg.wave_mode)
            MODE_SQUARE:   w_val = r5_inside ? $signed({1'b0, i_cfg.amplitude}) : '0;
            MODE_TRIANGLE: w_val = r5_inside ? r5_tri : '0;
            MODE_COS:      w_val = r5_inside ? r5_cos : '0;
            MODE_COS_SQ:   w_val = r5_inside ? w_sq : '0;
            MODE_CARRIER:  w_val = r5_cos;
            default:       w_val = '0;
        endcase
    end

    logic signed [15:0] r_value;
    logic signed [15:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (w_ld[5]) begin
            r_value  <= r5_zero ? '0 : w_val;
            r_offset <= r5_zero ? '0 : r5_d;
        end
    end

    assign o_sample_value  = r_value;
    assign o_center_offset = r_offset;

endmodule

FILE: rtl/windowed_pulse_wave_generator.sv
// channel   | valid    | ready    | payload
// ----------+----------+----------+----------------------------------
// input     | i_valid  | o_ready  | i_sample_index
// output    | o_valid  | i_ready  | o_sample_value, o_center_offset
// config    | psel/penable/pwrite | paddr, pwdata, prdata, pready
//
// one sample per clock sustained while the output is not stalled
// six register stages: offset, products, rom read, cosine products, rounding, mode select
// synchronous active-low reset clears valid bits and config registers
// stage-by-stage ready: a stalled output holds, empty stages still fill
module windowed_pulse_wave_generator
    import wpw_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_sample_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample_value,
    output logic signed [15:0] o_center_offset
);

    t_cfg w_cfg;

    wpw_cfg u_cfg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .o_cfg  (w_cfg)
    );

    wpw_datapath #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample_index (i_sample_index),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sample_value (o_sample_value),
        .o_center_offset(o_center_offset)
    );

endmodule

FILE: rtl/wpw_checker.sv
module wpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic [15:0] i_sample_index,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_sample_value,
    input logic [15:0] o_center_offset
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input blocked while output side is free");

    a_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_sample_index == 16'd0)
        ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        |=> (o_valid && o_sample_value == 16'd0 && o_center_offset == 16'd0))
        else $error("index zero transaction not zero at output");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_sample_value) && $stable(o_center_offset)))
        else $error("stalled output transaction changed");

endmodule

bind windowed_pulse_wave_generator wpw_checker u_chk (.*);
